### sv/cmsvl_pkg.sv
// ----------------------------------------------------------------------------
// Cascaded motor speed / voltage loop package
// Shared widths, limits, register indexes, payload types and the divide-by-ten
// helper of the cascaded PI motor controller.
// ----------------------------------------------------------------------------
package cmsvl_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int TARGET_W      = 12;
    localparam int CHARGE_DUTY_W = 10;
    localparam int DISCHARGE_W   = 9;
    localparam int SPEED_I_W     = 16;
    localparam int CHARGE_I_W    = 14;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 12;

    localparam int SAT_LIMIT          = 4000;
    localparam int SPEED_I_MAX        = 40000;
    localparam int CHARGE_I_MIN       = 50;
    localparam int CHARGE_I_MAX       = 9000;
    localparam int DISCHARGE_MAX      = 500;
    localparam int SPEED_TARGET_RESET = 600;

    // Widest of the target and the sample, plus sign and headroom.
    localparam int WIDE_W = (SAMPLE_BITS > TARGET_W) ? SAMPLE_BITS : TARGET_W;
    localparam int ERR_W  = WIDE_W + 2;
    localparam int CERR_W = WIDE_W + 1;
    localparam int SSUM_W = ((SPEED_I_W + 1 > ERR_W) ? SPEED_I_W + 1 : ERR_W) + 1;
    localparam int CSUM_W = ((CHARGE_I_W + 1 > CERR_W) ? CHARGE_I_W + 1 : CERR_W) + 1;
    localparam int PI_SUM_W = TARGET_W + 1;

    // floor(x / 3) for x below 2**(SAMPLE_BITS + 1) by reciprocal multiply.
    localparam int DIV3_SHIFT  = SAMPLE_BITS + 5;
    localparam int DIV3_MULT   = (2 ** DIV3_SHIFT + 2) / 3;
    localparam int DIV3_MULT_W = DIV3_SHIFT - 1;
    localparam int DIV3_PROD_W = SAMPLE_BITS + 1 + DIV3_MULT_W;

    // floor(x / 10) for x up to the speed integral limit.
    localparam int DIV10_SHIFT  = 19;
    localparam int DIV10_MULT   = (2 ** DIV10_SHIFT + 9) / 10;
    localparam int DIV10_MULT_W = 16;
    localparam int DIV10_PROD_W = SPEED_I_W + DIV10_MULT_W;
    localparam int DIV10_QUOT_W = DIV10_PROD_W - DIV10_SHIFT;

    localparam logic ACTION_VOLTAGE = 1'b0;
    localparam logic ACTION_SPEED   = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SPEED_TARGET,
        CFG_SPEED_LOOP_ENABLE,
        CFG_VOLTAGE_LOOP_ENABLE,
        CFG_MANUAL_VOLTAGE_TARGET
    } cfg_index_t;

    typedef struct packed {
        logic                   action;
        logic [SAMPLE_BITS-1:0] voltage_sample;
        logic [SAMPLE_BITS-1:0] current_sample;
    } in_t;

    typedef struct packed {
        logic [CHARGE_DUTY_W-1:0] charge_duty;
        logic [DISCHARGE_W-1:0]   discharge_duty;
        logic [TARGET_W-1:0]      voltage_target_out;
    } out_t;

    function automatic logic [DIV10_QUOT_W-1:0] div10(input logic [SPEED_I_W-1:0] x);
        logic [DIV10_PROD_W-1:0] prod;
        prod = DIV10_PROD_W'(x) * DIV10_PROD_W'(DIV10_MULT);
        return prod[DIV10_SHIFT +: DIV10_QUOT_W];
    endfunction

endpackage

### sv/cascaded_motor_speed_voltage_loop_core.sv
// ----------------------------------------------------------------------------
// Cascaded motor speed / voltage loop core
// Speed PI loop on estimated back-EMF feeding a voltage PI loop that drives
// charge and discharge PWM compare values, one control tick per transfer.
// ----------------------------------------------------------------------------
// The core takes one control tick per clock cycle unless out_stall holds it
// and returns one result per tick, in order, via the input and the result
// register. The input register holds the sample and the speed error (the
// back-EMF divide by three is done on the way in); the update step updates the
// loop state and loads the result register, so one tick's state update is ready
// for the next tick in the following cycle. The user must write configuration
// via cfg_we, cfg_index and cfg_data only while no tick is in flight; unchecked.
module cascaded_motor_speed_voltage_loop_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  cmsvl_pkg::in_t                       in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output cmsvl_pkg::out_t                      out_data,
    input  logic                                 cfg_we,
    input  logic [cmsvl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cmsvl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers
    logic [cmsvl_pkg::TARGET_W-1:0]     speed_target_reg;
    logic                               speed_en_reg;
    logic                               volt_en_reg;
    logic [cmsvl_pkg::TARGET_W-1:0]     manual_target_reg;

    // Loop state
    logic [cmsvl_pkg::SPEED_I_W-1:0]    si_reg;
    logic [cmsvl_pkg::SPEED_I_W-1:0]    si_next;
    logic [cmsvl_pkg::CHARGE_I_W-1:0]   ci_reg;
    logic [cmsvl_pkg::CHARGE_I_W-1:0]   ci_next;
    logic [cmsvl_pkg::DISCHARGE_W-1:0]  dl_reg;
    logic [cmsvl_pkg::DISCHARGE_W-1:0]  dl_next;
    logic [cmsvl_pkg::TARGET_W-1:0]     lvt_reg;
    logic [cmsvl_pkg::TARGET_W-1:0]     lvt_next;

    // Input register
    logic                                   s1_valid_reg;
    logic                                   s1_valid_next;
    logic                                   s1_action_reg;
    logic [cmsvl_pkg::SAMPLE_BITS-1:0]      s1_volt_reg;
    logic signed [cmsvl_pkg::ERR_W-1:0]     s1_err_reg;

    // Result register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    cmsvl_pkg::out_t        out_data_reg;
    cmsvl_pkg::out_t        out_data_next;

    logic in_accept;
    logic advance;

    // Input side arithmetic
    logic [cmsvl_pkg::DIV3_PROD_W-1:0]      div3_prod;
    logic [cmsvl_pkg::SAMPLE_BITS-1:0]      curr_third;
    logic signed [cmsvl_pkg::ERR_W-1:0]     speed_err;

    // Update stage arithmetic
    logic signed [cmsvl_pkg::SSUM_W-1:0]        si_sum;
    logic [cmsvl_pkg::SPEED_I_W-1:0]            si_clamped;
    logic [cmsvl_pkg::TARGET_W-1:0]             p_term;
    logic [cmsvl_pkg::DIV10_QUOT_W-1:0]         i_units;
    logic [cmsvl_pkg::PI_SUM_W-1:0]             pi_sum;
    logic [cmsvl_pkg::TARGET_W-1:0]             lvt_loop;
    logic [cmsvl_pkg::TARGET_W-1:0]             tif_now;
    logic signed [cmsvl_pkg::CERR_W-1:0]        c_err;
    logic signed [cmsvl_pkg::CERR_W-1:0]        c_drop;
    logic signed [cmsvl_pkg::CSUM_W-1:0]        ci_sum;
    logic [cmsvl_pkg::CHARGE_I_W-1:0]           ci_clamped;
    logic [cmsvl_pkg::DISCHARGE_W-1:0]          dl_loop;
    logic [cmsvl_pkg::DIV10_QUOT_W-1:0]         charge_units;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign advance        = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall       = s1_valid_reg && !advance;
    assign in_accept      = in_valid && !in_stall;
    assign s1_valid_next  = in_accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Speed error on the way in: target - (voltage - floor(2 * current / 3))
    // ------------------------------------------------------------------
    assign div3_prod  = cmsvl_pkg::DIV3_PROD_W'({in_data.current_sample, 1'b0})
                      * cmsvl_pkg::DIV3_PROD_W'(cmsvl_pkg::DIV3_MULT);
    assign curr_third = div3_prod[cmsvl_pkg::DIV3_SHIFT +: cmsvl_pkg::SAMPLE_BITS];
    assign speed_err  = $signed(cmsvl_pkg::ERR_W'(speed_target_reg))
                      + $signed(cmsvl_pkg::ERR_W'(curr_third))
                      - $signed(cmsvl_pkg::ERR_W'(in_data.voltage_sample));

    // ------------------------------------------------------------------
    // Speed loop
    // ------------------------------------------------------------------
    always_comb
    begin
        si_sum = $signed(cmsvl_pkg::SSUM_W'(si_reg)) + cmsvl_pkg::SSUM_W'(s1_err_reg);
        if (si_sum < 0)
        begin
            si_clamped = '0;
        end
        else if (si_sum > cmsvl_pkg::SPEED_I_MAX)
        begin
            si_clamped = cmsvl_pkg::SPEED_I_W'(cmsvl_pkg::SPEED_I_MAX);
        end
        else
        begin
            si_clamped = si_sum[cmsvl_pkg::SPEED_I_W-1:0];
        end

        if (s1_err_reg < 0)
        begin
            p_term = '0;
        end
        else if (s1_err_reg > cmsvl_pkg::SAT_LIMIT)
        begin
            p_term = cmsvl_pkg::TARGET_W'(cmsvl_pkg::SAT_LIMIT);
        end
        else
        begin
            p_term = s1_err_reg[cmsvl_pkg::TARGET_W-1:0];
        end

        i_units = cmsvl_pkg::div10(si_clamped);
        pi_sum  = cmsvl_pkg::PI_SUM_W'(p_term) + cmsvl_pkg::PI_SUM_W'(i_units);
        if (pi_sum > cmsvl_pkg::SAT_LIMIT)
        begin
            lvt_loop = cmsvl_pkg::TARGET_W'(cmsvl_pkg::SAT_LIMIT);
        end
        else
        begin
            lvt_loop = pi_sum[cmsvl_pkg::TARGET_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Voltage loop
    // ------------------------------------------------------------------
    always_comb
    begin
        tif_now = speed_en_reg ? lvt_reg : manual_target_reg;
        c_err   = $signed(cmsvl_pkg::CERR_W'(tif_now))
                - $signed(cmsvl_pkg::CERR_W'(s1_volt_reg));
        c_drop  = $signed(cmsvl_pkg::CERR_W'(s1_volt_reg))
                - $signed(cmsvl_pkg::CERR_W'(tif_now));

        ci_sum = $signed(cmsvl_pkg::CSUM_W'(ci_reg)) + cmsvl_pkg::CSUM_W'(c_err);
        if (ci_sum < cmsvl_pkg::CHARGE_I_MIN)
        begin
            ci_clamped = cmsvl_pkg::CHARGE_I_W'(cmsvl_pkg::CHARGE_I_MIN);
        end
        else if (ci_sum > cmsvl_pkg::CHARGE_I_MAX)
        begin
            ci_clamped = cmsvl_pkg::CHARGE_I_W'(cmsvl_pkg::CHARGE_I_MAX);
        end
        else
        begin
            ci_clamped = ci_sum[cmsvl_pkg::CHARGE_I_W-1:0];
        end

        // Discharge level, up to DISCHARGE_MAX, is twice the voltage overshoot.
        if (c_drop <= 0)
        begin
            dl_loop = '0;
        end
        else if (c_drop >= cmsvl_pkg::DISCHARGE_MAX / 2)
        begin
            dl_loop = cmsvl_pkg::DISCHARGE_W'(cmsvl_pkg::DISCHARGE_MAX);
        end
        else
        begin
            dl_loop = {c_drop[cmsvl_pkg::DISCHARGE_W-2:0], 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // State update and result
    // ------------------------------------------------------------------
    always_comb
    begin
        si_next  = si_reg;
        lvt_next = lvt_reg;
        ci_next  = ci_reg;
        dl_next  = dl_reg;

        unique case (s1_action_reg)
            cmsvl_pkg::ACTION_SPEED:
            begin
                if (speed_en_reg)
                begin
                    si_next  = si_clamped;
                    lvt_next = lvt_loop;
                end
                else
                begin
                    si_next = '0;
                end
            end
            cmsvl_pkg::ACTION_VOLTAGE:
            begin
                if (volt_en_reg)
                begin
                    ci_next = ci_clamped;
                    dl_next = dl_loop;
                end
                else
                begin
                    ci_next = '0;
                    dl_next = '0;
                end
            end
        endcase

        charge_units = cmsvl_pkg::div10(cmsvl_pkg::SPEED_I_W'(ci_next));
        out_data_next.charge_duty        = charge_units[cmsvl_pkg::CHARGE_DUTY_W-1:0];
        out_data_next.discharge_duty     = dl_next;
        out_data_next.voltage_target_out = speed_en_reg ? lvt_next : manual_target_reg;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_target_reg  <= cmsvl_pkg::TARGET_W'(cmsvl_pkg::SPEED_TARGET_RESET);
            speed_en_reg      <= 1'b0;
            volt_en_reg       <= 1'b0;
            manual_target_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cmsvl_pkg::cfg_index_t'(cfg_index))
                cmsvl_pkg::CFG_SPEED_TARGET:
                    speed_target_reg <= cfg_data[cmsvl_pkg::TARGET_W-1:0];
                cmsvl_pkg::CFG_SPEED_LOOP_ENABLE:
                    speed_en_reg <= cfg_data[0];
                cmsvl_pkg::CFG_VOLTAGE_LOOP_ENABLE:
                    volt_en_reg <= cfg_data[0];
                cmsvl_pkg::CFG_MANUAL_VOLTAGE_TARGET:
                    manual_target_reg <= cfg_data[cmsvl_pkg::TARGET_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            si_reg        <= '0;
            ci_reg        <= '0;
            dl_reg        <= '0;
            lvt_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                si_reg  <= si_next;
                ci_reg  <= ci_next;
                dl_reg  <= dl_next;
                lvt_reg <= lvt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg <= in_data.action;
            s1_volt_reg   <= in_data.voltage_sample;
            s1_err_reg    <= speed_err;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
